### design/rqwhd_pkg.sv
// Package for the run-queue window hotplug decider.
// Holds field widths, register indexes, action and function codes and reset values.
// No dependencies.
package rqwhd_pkg;

   localparam int LOAD_W   = 10;
   localparam int PERIOD_W = 16;
   localparam int CORES_W  = 3;
   localparam int ACTION_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Action codes of a result beat.
   localparam logic [ACTION_W-1:0] ACTION_NONE = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_UP   = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_DOWN = 2'd2;

   // Function codes of a request beat.
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_TOUCH = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UP_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_PER  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BUSY_PER     = 2'd3;

   // Core counts that the decision rule singles out.
   localparam logic [CORES_W-1:0] CORES_SINGLE = 3'd1;
   localparam logic [CORES_W-1:0] CORES_FULL   = 3'd4;

   // Reset values.
   localparam logic                RST_ENABLE       = 1'b1;
   localparam logic [LOAD_W-1:0]   RST_UP_THRESHOLD = 10'd11;
   localparam logic [PERIOD_W-1:0] RST_DEFAULT_PER  = 16'd1000;
   localparam logic [PERIOD_W-1:0] RST_BUSY_PER     = 16'd500;
   localparam logic [LOAD_W-1:0]   RST_OLDEST_LOAD  = 10'd6;

   // Request fields carried from the accept stage to the decision stage.
   typedef struct packed {
      logic               func;
      logic [CORES_W-1:0] cores;
      logic               susp;
   } item_type;

endpackage

### design/rqwhd_window.sv
// Sample window shift line with running sums of its older and newer halves.
// Depends on rqwhd_pkg.
module rqwhd_window #(
   parameter int WINDOW_LEN = 10,
   parameter int OLD_COUNT  = 5,
   parameter int SUM_W      = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  logic [rqwhd_pkg::LOAD_W-1:0] sample,
   output logic [rqwhd_pkg::LOAD_W-1:0] window [WINDOW_LEN],
   output logic [SUM_W-1:0]            sum_old,
   output logic [SUM_W-1:0]            sum_new
);

   logic [rqwhd_pkg::LOAD_W-1:0] window_ff [WINDOW_LEN];
   logic [SUM_W-1:0] sum_old_ff, sum_old_in;
   logic [SUM_W-1:0] sum_new_ff, sum_new_in;

   // The entry at the split point moves from the newer half into the older one,
   // the oldest entry drops out and the new sample enters the newer half.
   always_comb begin
      sum_old_in = sum_old_ff + SUM_W'(window_ff[OLD_COUNT]) - SUM_W'(window_ff[0]);
      sum_new_in = sum_new_ff + SUM_W'(sample) - SUM_W'(window_ff[OLD_COUNT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= (i == 0) ? rqwhd_pkg::RST_OLDEST_LOAD : '0;
         end
         sum_old_ff <= SUM_W'(rqwhd_pkg::RST_OLDEST_LOAD);
         sum_new_ff <= '0;
      end else if (shift_en) begin
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[WINDOW_LEN-1] <= sample;
         sum_old_ff <= sum_old_in;
         sum_new_ff <= sum_new_in;
      end
   end

   assign window  = window_ff;
   assign sum_old = sum_old_ff;
   assign sum_new = sum_new_ff;

endmodule

### design/rqwhd_max_tree.sv
// Balanced comparator tree that returns the largest of a set of unsigned values.
// No package dependencies.
module rqwhd_max_tree #(
   parameter int COUNT = 5,
   parameter int W     = 10
) (
   input  logic [W-1:0] vals [COUNT],
   output logic [W-1:0] max_val
);

   localparam int DEPTH  = $clog2(COUNT);
   localparam int LEAVES = 1 << DEPTH;

   logic [W-1:0] tree [DEPTH+1][LEAVES];

   // Unused leaves hold zero, which never wins against an unsigned value.
   always_comb begin
      tree = '{default: '0};
      for (int i = 0; i < COUNT; i++) begin
         tree[0][i] = vals[i];
      end
      for (int d = 0; d < DEPTH; d++) begin
         for (int i = 0; i < (LEAVES >> (d + 1)); i++) begin
            tree[d+1][i] = (tree[d][2*i+1] > tree[d][2*i]) ? tree[d][2*i+1] : tree[d][2*i];
         end
      end
   end

   assign max_val = tree[DEPTH][0];

endmodule

### design/rqwhd_estimate.sv
// Smoothed load estimate from the window: half averages by reciprocal
// multiplication and a peak-position test. Depends on rqwhd_pkg and rqwhd_max_tree.
module rqwhd_estimate #(
   parameter int WINDOW_LEN = 10,
   parameter int OLD_COUNT  = 5,
   parameter int SUM_W      = 13
) (
   input  logic [rqwhd_pkg::LOAD_W-1:0] window [WINDOW_LEN],
   input  logic [SUM_W-1:0]            sum_old,
   input  logic [SUM_W-1:0]            sum_new,
   output logic [rqwhd_pkg::LOAD_W-1:0] smoothed
);

   localparam int NEW_COUNT = WINDOW_LEN - OLD_COUNT;
   localparam int LW        = rqwhd_pkg::LOAD_W;

   // Exact division of a SUM_W-bit value by a constant d: multiply by
   // floor(2^(SUM_W+l)/d)+1 with l = clog2(d), then shift right by SUM_W+l.
   localparam int OLD_S = SUM_W + $clog2(OLD_COUNT);
   localparam int NEW_S = SUM_W + $clog2(NEW_COUNT);
   localparam logic [OLD_S:0] OLD_MUL = (OLD_S+1)'(((64'd1 << OLD_S) / OLD_COUNT) + 64'd1);
   localparam logic [NEW_S:0] NEW_MUL = (NEW_S+1)'(((64'd1 << NEW_S) / NEW_COUNT) + 64'd1);

   logic [LW-1:0] old_vals [OLD_COUNT];
   logic [LW-1:0] new_vals [NEW_COUNT];
   logic [LW-1:0] max_old, max_new;
   logic [SUM_W+OLD_S:0] prod_old;
   logic [SUM_W+NEW_S:0] prod_new;
   logic [LW-1:0] avg_old, avg_new;
   logic          peak_new;

   always_comb begin
      for (int i = 0; i < OLD_COUNT; i++) begin
         old_vals[i] = window[i];
      end
      for (int i = 0; i < NEW_COUNT; i++) begin
         new_vals[i] = window[OLD_COUNT+i];
      end
   end

   rqwhd_max_tree #(.COUNT(OLD_COUNT), .W(LW)) u_max_old (
      .vals    (old_vals),
      .max_val (max_old)
   );

   rqwhd_max_tree #(.COUNT(NEW_COUNT), .W(LW)) u_max_new (
      .vals    (new_vals),
      .max_val (max_new)
   );

   always_comb begin
      prod_old = (SUM_W+OLD_S+1)'(sum_old) * (SUM_W+OLD_S+1)'(OLD_MUL);
      prod_new = (SUM_W+NEW_S+1)'(sum_new) * (SUM_W+NEW_S+1)'(NEW_MUL);
      avg_old  = prod_old[OLD_S +: LW];
      avg_new  = prod_new[NEW_S +: LW];
      // The first occurrence of the maximum is new only if the newer half
      // strictly beats the older one; an all-zero window counts as not new.
      peak_new = max_new > max_old;
      smoothed = (avg_old < avg_new && !peak_new) ? avg_old : avg_new;
   end

endmodule

### design/runqueue_window_hotplug_decider_core.sv
// Run-queue window hotplug decider, top level.
// An accepted request beat moves through stage one into the result register.
// Throughput: one request beat per cycle while results are taken; the window and its
// running sums update at accept; the estimate and decision settle in the following stage.
// Reset (synchronous, active high) restores the register defaults, the window
// (oldest entry 6, the rest 0), the period (the default period) and empties both stages.
module runqueue_window_hotplug_decider_core #(
   parameter int WINDOW_LEN = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [rqwhd_pkg::LOAD_W-1:0]          req_load_sample,
   input  logic [rqwhd_pkg::CORES_W-1:0]         req_cores_online,
   input  logic                                  req_is_suspended,
   // Result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rqwhd_pkg::ACTION_W-1:0]        rsp_action,
   output logic [rqwhd_pkg::LOAD_W-1:0]          rsp_smoothed_load,
   output logic [rqwhd_pkg::PERIOD_W-1:0]        rsp_period_ms,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rqwhd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rqwhd_pkg::CSR_DATA_W-1:0]      csr_data
);

   // The older half holds the lower half of the window, rounded down, and the
   // newer half the rest. The sum width covers a full newer half of maximal samples.
   localparam int OLD_COUNT = WINDOW_LEN / 2;
   localparam int NEW_COUNT = WINDOW_LEN - OLD_COUNT;
   localparam int SUM_W     = rqwhd_pkg::LOAD_W + $clog2(NEW_COUNT);

   // Configuration registers. Writes are always taken; indexes past the list
   // do not exist with a two-bit index.
   logic                              enable_ff;
   logic [rqwhd_pkg::LOAD_W-1:0]      up_threshold_ff;
   logic [rqwhd_pkg::PERIOD_W-1:0]    default_period_ff;
   logic [rqwhd_pkg::PERIOD_W-1:0]    busy_period_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= rqwhd_pkg::RST_ENABLE;
         up_threshold_ff   <= rqwhd_pkg::RST_UP_THRESHOLD;
         default_period_ff <= rqwhd_pkg::RST_DEFAULT_PER;
         busy_period_ff    <= rqwhd_pkg::RST_BUSY_PER;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rqwhd_pkg::REG_ENABLE:       enable_ff         <= csr_data[0];
            rqwhd_pkg::REG_UP_THRESHOLD: up_threshold_ff   <= csr_data[rqwhd_pkg::LOAD_W-1:0];
            rqwhd_pkg::REG_DEFAULT_PER:  default_period_ff <= csr_data;
            rqwhd_pkg::REG_BUSY_PER:     busy_period_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline control. Stage one holds an accepted request whose window update
   // has already happened; the result register holds the finished beat. Stage
   // one moves on whenever the result register is empty or being drained, so a
   // new request is taken in the same cycle a waiting result is handed over.
   logic                 s1_valid_ff;
   rqwhd_pkg::item_type  s1_item_ff;
   logic                 rsp_valid_ff;
   logic                 req_accept;
   logic                 s1_advance;
   logic                 shift_en;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   // Only an enabled sample tick moves the window; touch beats and disabled
   // ticks leave it alone.
   assign shift_en = req_accept && (req_func == rqwhd_pkg::FUNC_TICK) && enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.func  <= req_func;
         s1_item_ff.cores <= req_cores_online;
         s1_item_ff.susp  <= req_is_suspended;
      end
   end

   // Window shift line with running half sums.
   logic [rqwhd_pkg::LOAD_W-1:0] window [WINDOW_LEN];
   logic [SUM_W-1:0]             sum_old;
   logic [SUM_W-1:0]             sum_new;
   logic [rqwhd_pkg::LOAD_W-1:0] estimate;

   rqwhd_window #(
      .WINDOW_LEN (WINDOW_LEN),
      .OLD_COUNT  (OLD_COUNT),
      .SUM_W      (SUM_W)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (shift_en),
      .sample   (req_load_sample),
      .window   (window),
      .sum_old  (sum_old),
      .sum_new  (sum_new)
   );

   // The window only moves on an accept, which cannot happen while stage one
   // stalls, so the estimate below always belongs to the item in stage one.
   rqwhd_estimate #(
      .WINDOW_LEN (WINDOW_LEN),
      .OLD_COUNT  (OLD_COUNT),
      .SUM_W      (SUM_W)
   ) u_estimate (
      .window   (window),
      .sum_old  (sum_old),
      .sum_new  (sum_new),
      .smoothed (estimate)
   );

   // Decision stage. The period register doubles as the period field of the
   // result beat: both change only when stage one moves into the result register.
   logic [rqwhd_pkg::ACTION_W-1:0] action_ff, action_in;
   logic [rqwhd_pkg::LOAD_W-1:0]   load_ff, load_in;
   logic [rqwhd_pkg::PERIOD_W-1:0] period_ff, period_in;

   always_comb begin
      action_in = rqwhd_pkg::ACTION_NONE;
      load_in   = '0;
      period_in = period_ff;
      if (s1_item_ff.func == rqwhd_pkg::FUNC_TOUCH) begin
         // A touch boost picks the busy period regardless of enable or suspend.
         period_in = busy_period_ff;
      end else if (enable_ff) begin
         load_in = estimate;
         // While suspended the estimate is still reported but nothing is acted on.
         if (!s1_item_ff.susp) begin
            if (s1_item_ff.cores == rqwhd_pkg::CORES_SINGLE && estimate >= up_threshold_ff) begin
               action_in = rqwhd_pkg::ACTION_UP;
               period_in = busy_period_ff;
            end else if (s1_item_ff.cores == rqwhd_pkg::CORES_FULL && estimate != '0) begin
               action_in = rqwhd_pkg::ACTION_NONE;
            end else begin
               action_in = rqwhd_pkg::ACTION_DOWN;
               period_in = default_period_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         period_ff    <= rqwhd_pkg::RST_DEFAULT_PER;
      end else begin
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
            period_ff    <= period_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         action_ff <= action_in;
         load_ff   <= load_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = action_ff;
   assign rsp_smoothed_load = load_ff;
   assign rsp_period_ms     = period_ff;

endmodule

### tb/hotplug_decision_checker.sv
// Checker for the run-queue window hotplug decider: it watches the request,
// result and register write channels, predicts every result beat and compares it.
// Depends on rqwhd_pkg for field widths, codes, register indexes and reset values.
module hotplug_decision_checker #(
   parameter int WINDOW_LEN = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [rqwhd_pkg::LOAD_W-1:0]          req_load_sample,
   input  logic [rqwhd_pkg::CORES_W-1:0]         req_cores_online,
   input  logic                                  req_is_suspended,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [rqwhd_pkg::ACTION_W-1:0]        rsp_action,
   input  logic [rqwhd_pkg::LOAD_W-1:0]          rsp_smoothed_load,
   input  logic [rqwhd_pkg::PERIOD_W-1:0]        rsp_period_ms,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [rqwhd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rqwhd_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                    fail_count,
   output int                                    pending
);

   localparam int OLD_CNT = WINDOW_LEN / 2;
   localparam int NEW_CNT = WINDOW_LEN - OLD_CNT;

   typedef struct packed {
      logic [rqwhd_pkg::ACTION_W-1:0] action;
      logic [rqwhd_pkg::LOAD_W-1:0]   load;
      logic [rqwhd_pkg::PERIOD_W-1:0] period;
   } decision_type;

   // Shadow copy of the block's registers and state.
   logic                           en;
   logic [rqwhd_pkg::LOAD_W-1:0]   up_thr;
   logic [rqwhd_pkg::PERIOD_W-1:0] default_per;
   logic [rqwhd_pkg::PERIOD_W-1:0] busy_per;
   logic [rqwhd_pkg::LOAD_W-1:0]   load_hist [WINDOW_LEN];
   logic [rqwhd_pkg::PERIOD_W-1:0] cur_period;

   decision_type expected_decisions [$];
   int           errors = 0;
   int           waiting = 0;

   assign fail_count = errors;
   assign pending    = waiting;

   // Shifts the sample into the history on an enabled tick and derives the decision.
   function automatic decision_type predict_decision(
      input logic                          func,
      input logic [rqwhd_pkg::LOAD_W-1:0]  sample,
      input logic [rqwhd_pkg::CORES_W-1:0] cores,
      input logic                          susp);
      decision_type d;
      int unsigned  sum_old;
      int unsigned  sum_new;
      int unsigned  peak;
      int unsigned  estimate;
      bit           peak_new;
      d.action = rqwhd_pkg::ACTION_NONE;
      d.load   = '0;
      if (func == rqwhd_pkg::FUNC_TOUCH) begin
         cur_period = busy_per;
      end else if (en) begin
         for (int i = 0; i < WINDOW_LEN - 1; i++) load_hist[i] = load_hist[i + 1];
         load_hist[WINDOW_LEN - 1] = sample;
         sum_old  = 0;
         sum_new  = 0;
         peak     = 0;
         peak_new = 1'b0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            if (i >= OLD_CNT) sum_new += 32'(load_hist[i]);
            else sum_old += 32'(load_hist[i]);
            // Only a strictly larger value moves the peak, so the first one wins.
            if (32'(load_hist[i]) > peak) begin
               peak     = 32'(load_hist[i]);
               peak_new = (i >= OLD_CNT);
            end
         end
         if (sum_old / OLD_CNT < sum_new / NEW_CNT && !peak_new) estimate = sum_old / OLD_CNT;
         else estimate = sum_new / NEW_CNT;
         d.load = estimate[rqwhd_pkg::LOAD_W-1:0];
         if (!susp) begin
            if (cores == rqwhd_pkg::CORES_SINGLE && estimate >= 32'(up_thr)) begin
               d.action   = rqwhd_pkg::ACTION_UP;
               cur_period = busy_per;
            end else if (cores == rqwhd_pkg::CORES_FULL && estimate >= 1) begin
               d.action = rqwhd_pkg::ACTION_NONE;
            end else begin
               d.action   = rqwhd_pkg::ACTION_DOWN;
               cur_period = default_per;
            end
         end
      end
      d.period = cur_period;
      return d;
   endfunction

   always @(posedge clock) begin : watch
      decision_type want;
      decision_type got;
      if (reset) begin
         en          = rqwhd_pkg::RST_ENABLE;
         up_thr      = rqwhd_pkg::RST_UP_THRESHOLD;
         default_per = rqwhd_pkg::RST_DEFAULT_PER;
         busy_per    = rqwhd_pkg::RST_BUSY_PER;
         for (int i = 0; i < WINDOW_LEN; i++) load_hist[i] = '0;
         load_hist[0] = rqwhd_pkg::RST_OLDEST_LOAD;
         cur_period   = rqwhd_pkg::RST_DEFAULT_PER;
         expected_decisions.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.action = rsp_action;
            got.load   = rsp_smoothed_load;
            got.period = rsp_period_ms;
            if (expected_decisions.size() == 0) begin
               $display("%0t: result beat with nothing expected: action %0d load %0d period %0d",
                        $time, got.action, got.load, got.period);
               errors++;
            end else begin
               want = expected_decisions.pop_front();
               if (got.action !== want.action) begin
                  $display("%0t: action expected %0d, got %0d", $time, want.action, got.action);
                  errors++;
               end
               if (got.load !== want.load) begin
                  $display("%0t: smoothed_load expected %0d, got %0d",
                           $time, want.load, got.load);
                  errors++;
               end
               if (got.period !== want.period) begin
                  $display("%0t: period_ms expected %0d, got %0d",
                           $time, want.period, got.period);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rqwhd_pkg::REG_ENABLE:       en          = csr_data[0];
               rqwhd_pkg::REG_UP_THRESHOLD: up_thr      = csr_data[rqwhd_pkg::LOAD_W-1:0];
               rqwhd_pkg::REG_DEFAULT_PER:  default_per = csr_data[rqwhd_pkg::PERIOD_W-1:0];
               rqwhd_pkg::REG_BUSY_PER:     busy_per    = csr_data[rqwhd_pkg::PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_decisions.push_back(predict_decision(req_func, req_load_sample,
                                                          req_cores_online,
                                                          req_is_suspended));
         end
      end
      waiting = expected_decisions.size();
   end

endmodule

### tb/runqueue_window_hotplug_decider_core_tb.sv
// Testbench top for the run-queue window hotplug decider core.
// Drives request, result-ready and register write channels and gives the verdict;
// depends on rqwhd_pkg, the decider core and hotplug_decision_checker.
module runqueue_window_hotplug_decider_core_tb;

   localparam int WINDOW_LEN      = 10;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 85;
   // This leaves a wide margin over the slowest legal run.
   localparam int CYCLE_LIMIT     = 200000;
   // Results come from a registered stage, so a short tail catches stray beats.
   localparam int TAIL_CYCLES     = 10;

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_func = rqwhd_pkg::FUNC_TICK;
   logic [rqwhd_pkg::LOAD_W-1:0]     req_load_sample = '0;
   logic [rqwhd_pkg::CORES_W-1:0]    req_cores_online = rqwhd_pkg::CORES_SINGLE;
   logic                             req_is_suspended = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [rqwhd_pkg::ACTION_W-1:0]   rsp_action;
   logic [rqwhd_pkg::LOAD_W-1:0]     rsp_smoothed_load;
   logic [rqwhd_pkg::PERIOD_W-1:0]   rsp_period_ms;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [rqwhd_pkg::CSR_IDX_W-1:0]  csr_index = rqwhd_pkg::REG_ENABLE;
   logic [rqwhd_pkg::CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int pending;

   // Random stimulus state: the load level that a run of ticks hovers around,
   // the threshold currently programmed, and how many beats remain in a burst.
   int level = 0;
   int thr_now = 0;
   int burst_left = 0;

   int             cycle_count = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             ready_left = 0;
   int             ready_tick = 0;

   always #5 clock = ~clock;

   runqueue_window_hotplug_decider_core #(
      .WINDOW_LEN(WINDOW_LEN)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_load_sample  (req_load_sample),
      .req_cores_online (req_cores_online),
      .req_is_suspended (req_is_suspended),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_smoothed_load(rsp_smoothed_load),
      .rsp_period_ms    (rsp_period_ms),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   hotplug_decision_checker #(
      .WINDOW_LEN(WINDOW_LEN)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_load_sample  (req_load_sample),
      .req_cores_online (req_cores_online),
      .req_is_suspended (req_is_suspended),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_smoothed_load(rsp_smoothed_load),
      .rsp_period_ms    (rsp_period_ms),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // Watchdog. A hung handshake or a lost result beat ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL runqueue_window_hotplug_decider_core");
         $finish;
      end
   end

   // The result receiver changes behavior after each random stretch, not tied to the
   // sender: it takes every beat, flips a coin each cycle, or is ready only on ticks
   // that are multiples of six, so stalls land on every pipeline phase.
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_left = $urandom_range(16, 80);
      end
      ready_left--;
      ready_tick++;
      case (ready_mode)
         READY_ALWAYS: rsp_ready = 1'b1;
         READY_COIN:   rsp_ready = 1'($urandom_range(0, 1));
         default:      rsp_ready = (ready_tick % 6 == 0);
      endcase
   end

   // Presents one request beat at the falling edge and holds it until the
   // rising edge at which the core takes it. Valid stays high on return, so a
   // following call simply overwrites the payload at the next falling edge.
   task automatic send_item(input logic                          func,
                            input logic [rqwhd_pkg::LOAD_W-1:0]  sample,
                            input logic [rqwhd_pkg::CORES_W-1:0] cores,
                            input logic                          susp);
      @(negedge clock);
      req_valid        = 1'b1;
      req_func         = func;
      req_load_sample  = sample;
      req_cores_online = cores;
      req_is_suspended = susp;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_requests(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   task automatic write_reg(input logic [rqwhd_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [rqwhd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Every request produces exactly one result, so once nothing is expected
   // the core holds no work and the registers may be rewritten.
   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // One random request beat. Most beats are ticks whose samples hover around a
   // slowly moving level, so the window averages actually settle near the
   // threshold and both halves of the split matter; a tenth are wild samples.
   task automatic send_random_item;
      int                            sample;
      int                            pick;
      logic                          func;
      logic [rqwhd_pkg::CORES_W-1:0] cores;
      logic                          susp;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 6));
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      if ($urandom_range(0, 11) == 0) begin
         case ($urandom_range(0, 5))
            0, 1:    level = thr_now + int'($urandom_range(0, 6)) - 3;
            2:       level = $urandom_range(0, 15);
            3:       level = 1023;
            4:       level = 0;
            default: level = $urandom_range(0, 1023);
         endcase
      end
      if ($urandom_range(0, 9) == 0) sample = $urandom_range(0, 1023);
      else sample = level + int'($urandom_range(0, 8)) - 4;
      if (sample < 0) sample = 0;
      if (sample > 1023) sample = 1023;
      func = ($urandom_range(0, 6) == 0) ? rqwhd_pkg::FUNC_TOUCH : rqwhd_pkg::FUNC_TICK;
      pick = $urandom_range(0, 9);
      if (pick < 4) cores = rqwhd_pkg::CORES_SINGLE;
      else if (pick < 7) cores = rqwhd_pkg::CORES_FULL;
      else if (pick < 9) cores = 3'($urandom_range(2, 3));
      else cores = 3'($urandom_range(0, 7));
      susp = ($urandom_range(0, 9) == 0);
      send_item(func, sample[rqwhd_pkg::LOAD_W-1:0], cores, susp);
   endtask

   initial begin : stimulus
      logic                             en;
      int                               thr;
      logic [rqwhd_pkg::PERIOD_W-1:0]   dper;
      logic [rqwhd_pkg::PERIOD_W-1:0]   bper;
      logic [rqwhd_pkg::CSR_DATA_W-1:0] data;

      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      thr_now = int'(rqwhd_pkg::RST_UP_THRESHOLD);

      // Directed part, run with the reset register values.
      // Zero samples flush the initial oldest entry, leaving an all-zero window
      // with no peak; the load is zero, so every core count goes down.
      send_item(rqwhd_pkg::FUNC_TICK, 10'd0, rqwhd_pkg::CORES_SINGLE, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd0, rqwhd_pkg::CORES_FULL, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd0, 3'd0, 1'b0);
      // A full-scale sample in the newer half: core up on one core, hold on four,
      // suspended with no action, and down for the counts the rule ignores.
      send_item(rqwhd_pkg::FUNC_TICK, 10'd1023, rqwhd_pkg::CORES_SINGLE, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd1023, rqwhd_pkg::CORES_FULL, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd1023, 3'd7, 1'b1);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd1023, 3'd5, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd0, 3'd6, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd0, 3'd2, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd0, 3'd3, 1'b0);
      // Touch beats ignore the other fields, whatever they hold.
      send_item(rqwhd_pkg::FUNC_TOUCH, 10'd1023, 3'd7, 1'b1);
      send_item(rqwhd_pkg::FUNC_TOUCH, 10'd0, 3'd0, 1'b0);
      // Build a window whose peak sits in the older half while the older
      // average is the lower one, so the older average is reported.
      send_item(rqwhd_pkg::FUNC_TICK, 10'd1000, rqwhd_pkg::CORES_SINGLE, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd0, rqwhd_pkg::CORES_FULL, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd0, rqwhd_pkg::CORES_FULL, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd0, 3'd2, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd0, 3'd3, 1'b0);
      repeat (5) send_item(rqwhd_pkg::FUNC_TICK, 10'd300, rqwhd_pkg::CORES_SINGLE, 1'b0);
      send_item(rqwhd_pkg::FUNC_TICK, 10'd512, rqwhd_pkg::CORES_FULL, 1'b1);

      // Random phases. Each one reprograms every register while the core is
      // idle; the first two hit the threshold and period extremes, the third
      // disables the decider, the fourth programs zero periods.
      for (int phase = 1; phase <= PHASES; phase++) begin
         drain();
         case (phase)
            1: begin
               en = 1'b1; thr = 0; dper = 16'd1; bper = 16'hFFFF;
            end
            2: begin
               en = 1'b1; thr = 1023; dper = 16'hFFFF; bper = 16'd1;
            end
            3: begin
               en = 1'b0; thr = $urandom_range(0, 1023);
               dper = 16'($urandom_range(1, 65535)); bper = 16'($urandom_range(1, 65535));
            end
            4: begin
               en = 1'b1; thr = $urandom_range(0, 40); dper = '0; bper = '0;
            end
            5: begin
               en = 1'b1; thr = $urandom_range(0, 1023);
               dper = 16'($urandom_range(1, 65535)); bper = 16'($urandom_range(1, 65535));
            end
            default: begin
               en = ($urandom_range(0, 3) != 0); thr = $urandom_range(0, 60);
               dper = 16'($urandom_range(1, 65535)); bper = 16'($urandom_range(1, 65535));
            end
         endcase
         // Bits above a register's width are filled with noise; the core must
         // ignore them.
         data = 16'($urandom);
         data[0] = en;
         write_reg(rqwhd_pkg::REG_ENABLE, data);
         data = 16'($urandom);
         data[rqwhd_pkg::LOAD_W-1:0] = thr[rqwhd_pkg::LOAD_W-1:0];
         write_reg(rqwhd_pkg::REG_UP_THRESHOLD, data);
         write_reg(rqwhd_pkg::REG_DEFAULT_PER, dper);
         write_reg(rqwhd_pkg::REG_BUSY_PER, bper);
         @(negedge clock);
         csr_valid = 1'b0;
         thr_now = thr;
         level   = thr;
         repeat (ITEMS_PER_PHASE) send_random_item();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS runqueue_window_hotplug_decider_core");
      end else begin
         $display("FAIL runqueue_window_hotplug_decider_core");
      end
      $finish;
   end

endmodule
